@@ hdl/tcrm_pkg.sv @@
// tcrm_pkg: shared constants and action codes for tile_checksum_remap_match
// no dependencies
`default_nettype none

package tcrm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CHECKSUM_W  = 32;
    localparam int NUM_W       = 10;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

endpackage

`default_nettype wire

@@ hdl/tcrm_if.sv @@
// tcrm_req_if / tcrm_rsp_if: valid/ready channels for request and result words
// depends on tcrm_pkg
`default_nettype none

interface tcrm_req_if;
    import tcrm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [CHECKSUM_W-1:0] checksum;

    modport source (output valid, output action, output checksum, input ready);
    modport sink   (input valid, input action, input checksum, output ready);
endinterface

interface tcrm_rsp_if;
    import tcrm_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [NUM_W-1:0] old_number;
    logic [NUM_W-1:0] new_number;
    logic             overflowed;

    modport source (output valid, output found, output old_number, output new_number,
                    output overflowed, input ready);
    modport sink   (input valid, input found, input old_number, input new_number,
                    input overflowed, output ready);
endinterface

`default_nettype wire

@@ hdl/tile_checksum_remap_match.sv @@
// tile_checksum_remap_match: clear, store and exact-match look-up of old tile checksums
// a look-up is a linear scan of the checksum memory, one read port entry per cycle, that
// stops at the first hit; its result then waits until the output register is taken
// result words go out through an output register. async reset zeroes the counts and overflow
// mark, memory contents are left as they are (entries at or above stored_count are never read)
`default_nettype none

module tile_checksum_remap_match (
    input  wire         clk,
    input  wire         rst_n,
    tcrm_req_if.sink    req,
    tcrm_rsp_if.source  rsp
);
    import tcrm_pkg::*;

    // one-hot control states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    // checksum memory, one write or one read per cycle
    logic [CHECKSUM_W-1:0] table_mem [TABLE_DEPTH];

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      stored_count_reg, stored_count_next;
    logic [CNT_W-1:0]      lookup_count_reg, lookup_count_next;
    logic                  overflow_reg, overflow_next;
    logic [CNT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  hit_reg, hit_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // payload registers, no reset
    logic [CHECKSUM_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [CHECKSUM_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     rd_idx_reg;
    logic                  found_reg, found_next;
    logic [NUM_W-1:0]      old_number_reg, old_number_next;
    logic [NUM_W-1:0]      new_number_reg, new_number_next;
    logic                  overflowed_reg, overflowed_next;

    // memory port controls
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic [ADDR_W-1:0]     mem_rd_addr;

    logic                  req_fire;
    logic                  match;
    logic                  issue;
    logic                  rsp_free;
    logic                  lookup_full;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    // compare the word read last cycle against the key
    assign match       = rd_valid_reg && (rd_data_reg == key_reg);
    // keep reading while stored entries remain and no hit has been seen
    assign issue       = (scan_addr_reg < stored_count_reg) && !match;
    assign rsp_free    = !rsp_valid_reg || rsp.ready;
    assign lookup_full = (lookup_count_reg == CNT_W'(TABLE_DEPTH));

    assign mem_wr_addr = stored_count_reg[ADDR_W-1:0];
    assign mem_rd_addr = scan_addr_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        stored_count_next = stored_count_reg;
        lookup_count_next = lookup_count_reg;
        overflow_next     = overflow_reg;
        scan_addr_next    = scan_addr_reg;
        rd_valid_next     = 1'b0;
        hit_next          = hit_reg;
        key_next          = key_reg;
        hit_idx_next      = hit_idx_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        found_next        = found_reg;
        old_number_next   = old_number_reg;
        new_number_next   = new_number_reg;
        overflowed_next   = overflowed_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.action)
                        ACT_CLEAR:
                        begin
                            stored_count_next = '0;
                            lookup_count_next = '0;
                            overflow_next     = 1'b0;
                        end
                        ACT_STORE:
                        begin
                            // append, or drop and flag once the table is full
                            if (stored_count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                mem_we            = 1'b1;
                                stored_count_next = stored_count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            key_next       = req.checksum;
                            scan_addr_next = '0;
                            hit_next       = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            // unused code, no effect
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    // first hit in ascending order is the lowest old number
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                    state_next   = ST_RESULT;
                end
                else if (issue)
                begin
                    mem_re         = 1'b1;
                    rd_valid_next  = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    found_next      = hit_reg;
                    old_number_next = hit_reg ? NUM_W'(hit_idx_reg) : '0;
                    new_number_next = NUM_W'(lookup_count_reg);
                    overflowed_next = overflow_reg || lookup_full;
                    // look-up count saturates at the table depth
                    if (lookup_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        lookup_count_next = lookup_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            lookup_count_reg <= '0;
            overflow_reg     <= 1'b0;
            scan_addr_reg    <= '0;
            rd_valid_reg     <= 1'b0;
            hit_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            lookup_count_reg <= lookup_count_next;
            overflow_reg     <= overflow_next;
            scan_addr_reg    <= scan_addr_next;
            rd_valid_reg     <= rd_valid_next;
            hit_reg          <= hit_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        hit_idx_reg    <= hit_idx_next;
        found_reg      <= found_next;
        old_number_reg <= old_number_next;
        new_number_reg <= new_number_next;
        overflowed_reg <= overflowed_next;
    end

    // synchronous memory, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_wr_addr] <= req.checksum;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_rd_addr];
            rd_idx_reg  <= mem_rd_addr;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.old_number = old_number_reg;
    assign rsp.new_number = new_number_reg;
    assign rsp.overflowed = overflowed_reg;

endmodule

`default_nettype wire
